### rtl/record_table_with_undo_and_fifo_unit_defines.svh
// assertion macros for the record table unit
`ifndef RECORD_TABLE_WITH_UNDO_AND_FIFO_UNIT_DEFINES_SVH
`define RECORD_TABLE_WITH_UNDO_AND_FIFO_UNIT_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define RCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define RCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/rct_pkg.sv
// shared types and constants of the record table unit
package rct_pkg;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned SCORE_W = 14;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned STAT_W  = 3;

  // request codes carried in the input tuser
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 3'd0,
    ACT_SEARCH = 3'd1,
    ACT_UNDO   = 3'd2,
    ACT_DEQ    = 3'd3,
    ACT_LIST   = 3'd4
  } rct_act_e;

  // result codes carried in the output tuser
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_FOUND = 3'd1,
    STAT_MISS  = 3'd2,
    STAT_EMPTY = 3'd3,
    STAT_FULL  = 3'd4
  } rct_stat_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UNDO_POP,
    S_SCAN,
    S_SHIFT,
    S_FIFO_POP,
    S_LIST_RD,
    S_LIST_CAP,
    S_EMIT
  } rct_state_e;

  // one stored record, key in the low bits
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [KEY_W-1:0]   key;
  } rct_entry_t;

  // one result beat from the sequencer
  typedef struct packed {
    rct_stat_e          status;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic               last;
  } rct_result_t;

endpackage

### rtl/rct_ram.sv
// simple dual-port memory with one write port and one registered read port
module rct_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rct_ctrl.sv
// sequencer with the shared key compare and index counter
module rct_ctrl #(
  parameter int unsigned TableDepth = 16,
  parameter int unsigned FifoDepth  = 16,
  localparam int unsigned Taw = $clog2(TableDepth),
  localparam int unsigned Faw = $clog2(FifoDepth)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rct_pkg::ACT_W-1:0]     in_act_i,
  input  logic [rct_pkg::KEY_W-1:0]     in_key_i,
  input  logic [rct_pkg::SCORE_W-1:0]   in_score_i,
  // result side
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output rct_pkg::rct_result_t          res_o,
  // record list memory
  output logic                          list_we_o,
  output logic [Taw-1:0]                list_waddr_o,
  output rct_pkg::rct_entry_t           list_wdata_o,
  output logic                          list_re_o,
  output logic [Taw-1:0]                list_raddr_o,
  input  rct_pkg::rct_entry_t           list_rdata_i,
  // undo key stack memory
  output logic                          undo_we_o,
  output logic [Taw-1:0]                undo_waddr_o,
  output logic [rct_pkg::KEY_W-1:0]     undo_wdata_o,
  output logic                          undo_re_o,
  output logic [Taw-1:0]                undo_raddr_o,
  input  logic [rct_pkg::KEY_W-1:0]     undo_rdata_i,
  // fifo memory
  output logic                          fifo_we_o,
  output logic [Faw-1:0]                fifo_waddr_o,
  output rct_pkg::rct_entry_t           fifo_wdata_o,
  output logic                          fifo_re_o,
  output logic [Faw-1:0]                fifo_raddr_o,
  input  rct_pkg::rct_entry_t           fifo_rdata_i
);

  import rct_pkg::*;

  localparam int unsigned Tcw = $clog2(TableDepth + 1);
  localparam int unsigned Fcw = $clog2(FifoDepth + 1);

  rct_state_e          state_q, state_d;
  logic [ACT_W-1:0]    act_q, act_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [SCORE_W-1:0]  score_q, score_d;
  logic [Tcw-1:0]      list_cnt_q, list_cnt_d;
  logic [Tcw-1:0]      undo_cnt_q, undo_cnt_d;
  logic [Fcw-1:0]      fifo_cnt_q, fifo_cnt_d;
  logic [Faw-1:0]      head_q, head_d;
  logic [Tcw-1:0]      rd_idx_q, rd_idx_d;
  logic [Taw-1:0]      wr_idx_q, wr_idx_d;
  logic                pend_q, pend_d;
  rct_result_t         res_q, res_d;

  logic                full;
  logic                hit;
  logic                more;
  logic [Tcw-1:0]      rd_idx_inc;
  logic [Tcw-1:0]      undo_top;
  logic [Fcw:0]        tail_sum;
  logic [Fcw:0]        tail_wrap;
  logic [Faw-1:0]      head_inc;

  // shared compare and index arithmetic
  assign full       = (list_cnt_q >= Tcw'(TableDepth)) || (fifo_cnt_q >= Fcw'(FifoDepth))
                      || (undo_cnt_q >= Tcw'(TableDepth));
  assign hit        = pend_q && (list_rdata_i.key == key_q);
  assign more       = rd_idx_q < list_cnt_q;
  assign rd_idx_inc = rd_idx_q + Tcw'(1);
  assign undo_top   = undo_cnt_q - Tcw'(1);
  assign tail_sum   = {1'b0, Fcw'(head_q)} + {1'b0, fifo_cnt_q};
  assign tail_wrap  = (tail_sum >= (Fcw + 1)'(FifoDepth)) ?
                      tail_sum - (Fcw + 1)'(FifoDepth) : tail_sum;
  assign head_inc   = (head_q == Faw'(FifoDepth - 1)) ? '0 : head_q + Faw'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (act_q)
          ACT_ADD:    state_d = S_EMIT;
          ACT_SEARCH: state_d = S_SCAN;
          ACT_UNDO:   state_d = (undo_cnt_q == '0) ? S_EMIT : S_UNDO_POP;
          ACT_DEQ:    state_d = (fifo_cnt_q == '0) ? S_EMIT : S_FIFO_POP;
          ACT_LIST:   state_d = (list_cnt_q == '0) ? S_EMIT : S_LIST_RD;
          default:    state_d = S_IDLE;
        endcase
      end
      S_UNDO_POP: state_d = S_SCAN;
      S_SCAN: begin
        if (hit) begin
          state_d = (act_q == ACT_UNDO) ? S_SHIFT : S_EMIT;
        end else if (!more) begin
          state_d = S_EMIT;
        end
      end
      S_SHIFT: begin
        if (!more && !pend_q) begin
          state_d = S_EMIT;
        end
      end
      S_FIFO_POP: state_d = S_EMIT;
      S_LIST_RD:  state_d = S_LIST_CAP;
      S_LIST_CAP: state_d = S_EMIT;
      S_EMIT: begin
        if (res_ready_i) begin
          state_d = res_q.last ? S_IDLE : S_LIST_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // handshake and memory port controls
  always_comb begin
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    list_we_o    = 1'b0;
    list_waddr_o = list_cnt_q[Taw-1:0];
    list_wdata_o = '{score: score_q, key: key_q};
    list_re_o    = 1'b0;
    list_raddr_o = rd_idx_q[Taw-1:0];
    undo_we_o    = 1'b0;
    undo_waddr_o = undo_cnt_q[Taw-1:0];
    undo_wdata_o = key_q;
    undo_re_o    = 1'b0;
    undo_raddr_o = undo_top[Taw-1:0];
    fifo_we_o    = 1'b0;
    fifo_waddr_o = tail_wrap[Faw-1:0];
    fifo_wdata_o = '{score: score_q, key: key_q};
    fifo_re_o    = 1'b0;
    fifo_raddr_o = head_q;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_DECODE: begin
        if (act_q == ACT_ADD && !full) begin
          list_we_o = 1'b1;
          undo_we_o = 1'b1;
          fifo_we_o = 1'b1;
        end
        undo_re_o = (act_q == ACT_UNDO) && (undo_cnt_q != '0);
        fifo_re_o = (act_q == ACT_DEQ) && (fifo_cnt_q != '0);
      end
      S_SCAN: list_re_o = !hit && more;
      S_SHIFT: begin
        list_we_o    = pend_q;
        list_waddr_o = wr_idx_q;
        list_wdata_o = list_rdata_i;
        list_re_o    = more;
      end
      S_LIST_RD: list_re_o = 1'b1;
      S_EMIT:    res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    act_d      = act_q;
    key_d      = key_q;
    score_d    = score_q;
    list_cnt_d = list_cnt_q;
    undo_cnt_d = undo_cnt_q;
    fifo_cnt_d = fifo_cnt_q;
    head_d     = head_q;
    rd_idx_d   = rd_idx_q;
    wr_idx_d   = wr_idx_q;
    pend_d     = pend_q;
    res_d      = res_q;
    case (state_q)
      S_IDLE: begin
        act_d    = in_act_i;
        key_d    = in_key_i;
        score_d  = in_score_i;
        rd_idx_d = '0;
        pend_d   = 1'b0;
      end
      S_DECODE: begin
        res_d = '{status: STAT_OK, key: '0, score: '0, last: 1'b1};
        case (act_q)
          ACT_ADD: begin
            if (full) begin
              res_d.status = STAT_FULL;
            end else begin
              list_cnt_d = list_cnt_q + Tcw'(1);
              undo_cnt_d = undo_cnt_q + Tcw'(1);
              fifo_cnt_d = fifo_cnt_q + Fcw'(1);
            end
          end
          ACT_UNDO: if (undo_cnt_q == '0) res_d.status = STAT_EMPTY;
          ACT_DEQ:  if (fifo_cnt_q == '0) res_d.status = STAT_EMPTY;
          ACT_LIST: if (list_cnt_q == '0) res_d.status = STAT_EMPTY;
          default: ;
        endcase
      end
      S_UNDO_POP: begin
        key_d      = undo_rdata_i;
        undo_cnt_d = undo_top;
      end
      S_SCAN: begin
        if (hit) begin
          res_d    = '{status: STAT_FOUND, key: key_q, score: list_rdata_i.score, last: 1'b1};
          wr_idx_d = Taw'(rd_idx_q - Tcw'(1));
          pend_d   = 1'b0;
        end else if (more) begin
          rd_idx_d = rd_idx_inc;
          pend_d   = 1'b1;
        end else if (act_q == ACT_UNDO) begin
          res_d = '{status: STAT_OK, key: key_q, score: '0, last: 1'b1};
        end else begin
          res_d = '{status: STAT_MISS, key: '0, score: '0, last: 1'b1};
        end
      end
      S_SHIFT: begin
        if (pend_q) begin
          wr_idx_d = wr_idx_q + Taw'(1);
        end
        if (more) begin
          rd_idx_d = rd_idx_inc;
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            list_cnt_d = list_cnt_q - Tcw'(1);
            res_d      = '{status: STAT_OK, key: key_q, score: '0, last: 1'b1};
          end
        end
      end
      S_FIFO_POP: begin
        res_d      = '{status: STAT_OK, key: fifo_rdata_i.key, score: fifo_rdata_i.score,
                       last: 1'b1};
        head_d     = head_inc;
        fifo_cnt_d = fifo_cnt_q - Fcw'(1);
      end
      S_LIST_CAP: begin
        res_d    = '{status: STAT_OK, key: list_rdata_i.key, score: list_rdata_i.score,
                     last: (rd_idx_inc == list_cnt_q)};
        rd_idx_d = rd_idx_inc;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      list_cnt_q <= '0;
      undo_cnt_q <= '0;
      fifo_cnt_q <= '0;
      head_q     <= '0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      list_cnt_q <= list_cnt_d;
      undo_cnt_q <= undo_cnt_d;
      fifo_cnt_q <= fifo_cnt_d;
      head_q     <= head_d;
      pend_q     <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    key_q    <= key_d;
    score_q  <= score_d;
    rd_idx_q <= rd_idx_d;
    wr_idx_q <= wr_idx_d;
    res_q    <= res_d;
  end

  assign res_o = res_q;

endmodule

### rtl/record_table_with_undo_and_fifo_unit.sv
// top level of the record table with undo stack and fifo
//
// Requests arrive on the s_axis channel: tuser carries the action (add,
// search, undo, dequeue, list) and tdata the key and score. Results leave on
// the m_axis channel: tuser carries the status, tdata the key and score, and
// tlast marks the final beat caused by a request.
// One request is in work at a time; s_axis_tready_o is high only while the
// sequencer is idle. Search walks the record list through one memory read
// port at one entry per cycle. Undo stops its scan at the match and then
// moves every later record down by one, so the list is walked once. List
// reads, captures and emits each record beat in turn.
// A result beat waits in an output register, so the sequencer hands over a
// beat and goes on while the receiver holds tready low; when that register
// is still full the sequencer waits.
// Reset clears the counts and the fifo head, so all stores start empty; the
// memories themselves are not cleared and no clearing pass is needed.
module record_table_with_undo_and_fifo_unit #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned FIFO_DEPTH  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // key [15:0], score [29:16], zero pad
  input  logic [2:0]  s_axis_tuser_i,  // action [2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // out_key [15:0], out_score [29:16], zero pad
  output logic [2:0]  m_axis_tuser_o,  // status [2:0]
  output logic        m_axis_tlast_o   // last
);

  import rct_pkg::*;

  `include "record_table_with_undo_and_fifo_unit_defines.svh"

  localparam int unsigned Taw = $clog2(TABLE_DEPTH);
  localparam int unsigned Faw = $clog2(FIFO_DEPTH);

  logic                res_valid;
  logic                res_ready;
  rct_result_t         res;

  logic                list_we, list_re;
  logic [Taw-1:0]      list_waddr, list_raddr;
  rct_entry_t          list_wdata, list_rdata;
  logic                undo_we, undo_re;
  logic [Taw-1:0]      undo_waddr, undo_raddr;
  logic [KEY_W-1:0]    undo_wdata, undo_rdata;
  logic                fifo_we, fifo_re;
  logic [Faw-1:0]      fifo_waddr, fifo_raddr;
  rct_entry_t          fifo_wdata, fifo_rdata;

  logic                out_valid_q;
  rct_result_t         out_q;

  // sequencer
  rct_ctrl #(
    .TableDepth (TABLE_DEPTH),
    .FifoDepth  (FIFO_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_act_i     (s_axis_tuser_i),
    .in_key_i     (s_axis_tdata_i[KEY_W-1:0]),
    .in_score_i   (s_axis_tdata_i[KEY_W+SCORE_W-1:KEY_W]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .list_we_o    (list_we),
    .list_waddr_o (list_waddr),
    .list_wdata_o (list_wdata),
    .list_re_o    (list_re),
    .list_raddr_o (list_raddr),
    .list_rdata_i (list_rdata),
    .undo_we_o    (undo_we),
    .undo_waddr_o (undo_waddr),
    .undo_wdata_o (undo_wdata),
    .undo_re_o    (undo_re),
    .undo_raddr_o (undo_raddr),
    .undo_rdata_i (undo_rdata),
    .fifo_we_o    (fifo_we),
    .fifo_waddr_o (fifo_waddr),
    .fifo_wdata_o (fifo_wdata),
    .fifo_re_o    (fifo_re),
    .fifo_raddr_o (fifo_raddr),
    .fifo_rdata_i (fifo_rdata)
  );

  // record list storage
  rct_ram #(
    .Width ($bits(rct_entry_t)),
    .Depth (TABLE_DEPTH)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .re_i    (list_re),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  // undo key stack storage
  rct_ram #(
    .Width (KEY_W),
    .Depth (TABLE_DEPTH)
  ) u_undo_ram (
    .clk_i   (clk_i),
    .we_i    (undo_we),
    .waddr_i (undo_waddr),
    .wdata_i (undo_wdata),
    .re_i    (undo_re),
    .raddr_i (undo_raddr),
    .rdata_o (undo_rdata)
  );

  // fifo storage
  rct_ram #(
    .Width ($bits(rct_entry_t)),
    .Depth (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .re_i    (fifo_re),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  // output register takes a beat when empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.score, out_q.key};
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.last;

  // checks on the sequencer and output register
  `RCT_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "request taken while busy")
  `RCT_ASSERT_NOW(a_no_result_when_idle, s_axis_tready_o, !res_valid, "result beat while idle")
  `RCT_ASSERT_NEXT(a_result_loaded, res_valid && res_ready, m_axis_tvalid_o && (m_axis_tlast_o == $past(res.last)), "result beat lost")
  `RCT_ASSERT_NEXT(a_idle_after_last, res_valid && res_ready && res.last, s_axis_tready_o, "not idle after final beat")

endmodule

### bench/record_table_with_undo_and_fifo_unit_tb.sv
// self-checking testbench of the record table unit with undo stack and fifo
module record_table_with_undo_and_fifo_unit_tb;
  import rct_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int FIFO_DEPTH   = 16;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 34;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int REPORT_MAX   = 10;
  localparam int NUM_DIRECTED = 28;

  // action codes the block ignores
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  // kinds of random phase
  localparam int MIX_FILL     = 0;
  localparam int MIX_QUERY    = 1;
  localparam int MIX_DRAIN    = 2;

  // one expected result beat
  typedef struct {
    rct_stat_e          status;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic               last;
  } result_beat_t;

  // one directed request, status given only where it is obvious
  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic               typed;
    rct_stat_e          status;
  } request_row_t;

  localparam request_row_t DIRECTED [NUM_DIRECTED] = '{
    {ACT_LIST,   16'h0000, 14'd0,     1'b1, STAT_EMPTY},
    {ACT_UNDO,   16'h0000, 14'd0,     1'b1, STAT_EMPTY},
    {ACT_DEQ,    16'h0000, 14'd0,     1'b1, STAT_EMPTY},
    {ACT_SEARCH, 16'h0000, 14'd0,     1'b1, STAT_MISS},
    {ACT_ADD,    16'h0000, 14'd0,     1'b1, STAT_OK},
    {ACT_ADD,    16'hFFFF, 14'h3FFF,  1'b1, STAT_OK},
    {ACT_ADD,    16'h1234, 14'd10000, 1'b1, STAT_OK},
    {ACT_ADD,    16'h1234, 14'd1,     1'b1, STAT_OK},
    {ACT_ADD,    16'h8000, 14'd5000,  1'b1, STAT_OK},
    {ACT_ADD,    16'h0001, 14'd100,   1'b1, STAT_OK},
    {ACT_ADD,    16'h0002, 14'd200,   1'b1, STAT_OK},
    {ACT_ADD,    16'h00FF, 14'd8191,  1'b1, STAT_OK},
    {ACT_ADD,    16'h0100, 14'd8192,  1'b1, STAT_OK},
    {ACT_ADD,    16'h7FFF, 14'd9999,  1'b1, STAT_OK},
    {ACT_ADD,    16'hAAAA, 14'h1555,  1'b1, STAT_OK},
    {ACT_ADD,    16'h5555, 14'h2AAA,  1'b1, STAT_OK},
    {ACT_ADD,    16'h0003, 14'd3,     1'b1, STAT_OK},
    {ACT_ADD,    16'h0004, 14'd4,     1'b1, STAT_OK},
    {ACT_ADD,    16'h0005, 14'd5,     1'b1, STAT_OK},
    {ACT_ADD,    16'h0006, 14'd6,     1'b1, STAT_OK},
    {ACT_ADD,    16'h00AA, 14'd7,     1'b1, STAT_FULL},
    {ACT_SEARCH, 16'h1234, 14'd0,     1'b0, STAT_OK},
    {ACT_LIST,   16'h0000, 14'd0,     1'b0, STAT_OK},
    {ACT_UNDO,   16'h0000, 14'd0,     1'b0, STAT_OK},
    {ACT_ADD,    16'h0BAD, 14'd11,    1'b1, STAT_FULL},
    {ACT_DEQ,    16'h0000, 14'd0,     1'b0, STAT_OK},
    {ACT_SPARE_LO, 16'hFFFF, 14'h3FFF, 1'b0, STAT_OK},
    {ACT_SPARE_HI, 16'h0000, 14'd0,   1'b0, STAT_OK}
  };

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // stream signals
  logic               s_tvalid = 1'b0;
  logic [31:0]        s_tdata  = '0;
  logic [ACT_W-1:0]   s_tuser  = '0;
  logic               m_tready = 1'b0;
  logic               s_tready;
  logic               m_tvalid;
  logic [31:0]        m_tdata;
  logic [STAT_W-1:0]  m_tuser;
  logic               m_tlast;

  wire in_beat  = s_tvalid && s_tready;
  wire out_beat = m_tvalid && m_tready;

  record_table_with_undo_and_fifo_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),   // key [15:0], score [29:16], zero pad
    .s_axis_tuser_i (s_tuser),   // action [2:0]
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),   // out_key [15:0], out_score [29:16], zero pad
    .m_axis_tuser_o (m_tuser),   // status [2:0]
    .m_axis_tlast_o (m_tlast)    // last
  );

  // shadow copy of the record list, undo stack and fifo
  logic [KEY_W-1:0]   tbl_key   [TABLE_DEPTH];
  logic [SCORE_W-1:0] tbl_score [TABLE_DEPTH];
  int                 tbl_count = 0;
  logic [KEY_W-1:0]   undo_stk  [TABLE_DEPTH];
  int                 undo_depth = 0;
  logic [KEY_W-1:0]   q_key     [FIFO_DEPTH];
  logic [SCORE_W-1:0] q_score   [FIFO_DEPTH];
  int                 q_head = 0;
  int                 q_count = 0;

  result_beat_t model_out[$];
  result_beat_t awaited_results[$];
  int           mismatches = 0;
  int           burst_left = 8;

  // apply one request to the shadow state and collect its result beats
  task automatic model_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                               input logic [SCORE_W-1:0] score);
    result_beat_t beat;
    int           hit;
    logic         single;
    logic [KEY_W-1:0] popped;
    model_out.delete();
    beat.status = STAT_OK;
    beat.key    = '0;
    beat.score  = '0;
    beat.last   = 1'b1;
    single      = 1'b1;
    hit         = -1;
    case (act)
      ACT_ADD: begin
        if (tbl_count >= TABLE_DEPTH || q_count >= FIFO_DEPTH ||
            undo_depth >= TABLE_DEPTH) begin
          beat.status = STAT_FULL;
        end else begin
          tbl_key[tbl_count]   = key;
          tbl_score[tbl_count] = score;
          tbl_count++;
          undo_stk[undo_depth] = key;
          undo_depth++;
          q_key[(q_head + q_count) % FIFO_DEPTH]   = key;
          q_score[(q_head + q_count) % FIFO_DEPTH] = score;
          q_count++;
        end
      end
      ACT_SEARCH: begin
        for (int i = 0; i < tbl_count; i++)
          if (hit < 0 && tbl_key[i] == key) hit = i;
        if (hit < 0) begin
          beat.status = STAT_MISS;
        end else begin
          beat.status = STAT_FOUND;
          beat.key    = key;
          beat.score  = tbl_score[hit];
        end
      end
      ACT_UNDO: begin
        if (undo_depth == 0) begin
          beat.status = STAT_EMPTY;
        end else begin
          undo_depth--;
          popped = undo_stk[undo_depth];
          for (int i = 0; i < tbl_count; i++)
            if (hit < 0 && tbl_key[i] == popped) hit = i;
          // close the gap behind the removed record
          if (hit >= 0) begin
            for (int j = hit; j + 1 < tbl_count; j++) begin
              tbl_key[j]   = tbl_key[j + 1];
              tbl_score[j] = tbl_score[j + 1];
            end
            tbl_count--;
          end
          beat.key = popped;
        end
      end
      ACT_DEQ: begin
        if (q_count == 0) begin
          beat.status = STAT_EMPTY;
        end else begin
          beat.key   = q_key[q_head];
          beat.score = q_score[q_head];
          q_head     = (q_head + 1) % FIFO_DEPTH;
          q_count--;
        end
      end
      ACT_LIST: begin
        if (tbl_count == 0) begin
          beat.status = STAT_EMPTY;
        end else begin
          single = 1'b0;
          for (int i = 0; i < tbl_count; i++) begin
            beat.key   = tbl_key[i];
            beat.score = tbl_score[i];
            beat.last  = (i == tbl_count - 1);
            model_out.push_back(beat);
          end
        end
      end
      default: single = 1'b0;
    endcase
    if (single) model_out.push_back(beat);
  endtask

  // present one request, wait until it is taken, then keep the burst pacing
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                              input logic [SCORE_W-1:0] score, input logic typed,
                              input rct_stat_e typed_status);
    result_beat_t beat;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {2'b00, score, key};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    model_request(act, key, score);
    if (typed) begin
      beat.status = typed_status;
      beat.key    = '0;
      beat.score  = '0;
      beat.last   = 1'b1;
      awaited_results.push_back(beat);
    end else begin
      foreach (model_out[i]) awaited_results.push_back(model_out[i]);
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  // hold off new requests until every outstanding result has arrived
  task automatic wait_for_results();
    if (s_tvalid) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall pattern and result checking
  int           stall_left = 0;
  int           stall_mode = 0;
  int           stall_tick = 0;
  result_beat_t want;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 9) < 7);
      2:       m_tready <= ((stall_tick % 5) < 3);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
    if (rst_ni && out_beat) begin
      if (awaited_results.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected result beat: status %0d key %h score %0d last %b",
                   m_tuser, m_tdata[15:0], m_tdata[29:16], m_tlast);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (m_tuser !== want.status || m_tdata[15:0] !== want.key ||
            m_tdata[29:16] !== want.score || m_tdata[31:30] !== 2'b00 ||
            m_tlast !== want.last) begin
          if (mismatches < REPORT_MAX)
            $display("result mismatch: expected status %0d key %h score %0d last %b, %s%0d %h %0d %b",
                     want.status, want.key, want.score, want.last, "got ",
                     m_tuser, m_tdata[15:0], m_tdata[29:16], m_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (in_beat || out_beat) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // stimulus
  initial begin
    int kind;
    int taken;
    int r;
    int w_add;
    int w_search;
    int w_undo;
    int w_deq;
    int w_list;
    logic [ACT_W-1:0]   act;
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DIRECTED[i])
      send_request(DIRECTED[i].act, DIRECTED[i].key, DIRECTED[i].score,
                   DIRECTED[i].typed, DIRECTED[i].status);
    wait_for_results();

    // random phases with shifting action mixes
    for (int phase = 0; phase < PHASES; phase++) begin
      kind  = phase % 4;
      taken = 0;
      case (kind)
        MIX_FILL:  begin w_add = 60; w_search = 10; w_undo = 5;  w_deq = 5;  w_list = 15; end
        MIX_QUERY: begin w_add = 25; w_search = 35; w_undo = 10; w_deq = 5;  w_list = 20; end
        MIX_DRAIN: begin w_add = 10; w_search = 10; w_undo = 35; w_deq = 35; w_list = 5;  end
        default:   begin w_add = 30; w_search = 20; w_undo = 15; w_deq = 15; w_list = 15; end
      endcase
      while (taken < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < w_add) act = ACT_ADD;
        else if (r < w_add + w_search) act = ACT_SEARCH;
        else if (r < w_add + w_search + w_undo) act = ACT_UNDO;
        else if (r < w_add + w_search + w_undo + w_deq) act = ACT_DEQ;
        else if (r < w_add + w_search + w_undo + w_deq + w_list) act = ACT_LIST;
        else act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));

        // small key pool so duplicates and hits are common
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: key = KEY_W'($urandom_range(0, 7));
          6:                key = 16'hFFFF;
          7:                key = 16'h0000;
          default:          key = KEY_W'($urandom);
        endcase
        if (act == ACT_SEARCH && tbl_count > 0 && $urandom_range(0, 9) < 7)
          key = tbl_key[$urandom_range(0, tbl_count - 1)];

        case ($urandom_range(0, 9))
          0:       score = 14'd10000;
          1:       score = SCORE_W'($urandom_range(0, 16383));
          default: score = SCORE_W'($urandom_range(0, 10000));
        endcase

        send_request(act, key, score, 1'b0, STAT_OK);
        if (act <= ACT_LIST) taken++;
      end
      wait_for_results();
    end

    // drain and finish
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/rct_pkg.sv
rtl/rct_ram.sv
rtl/rct_ctrl.sv
rtl/record_table_with_undo_and_fifo_unit.sv
bench/record_table_with_undo_and_fifo_unit_tb.sv
